>>> design/pat_pkg.sv
package pat_pkg;

  // Default sizing of the per-instance tables
  localparam int unsigned PAT_INSTANCES   = 65536;
  localparam int unsigned PAT_VALUE_WORDS = 8;

  // Fixed field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned INST_W     = 16;
  localparam int unsigned RND_W      = 16;
  localparam int unsigned ID_W       = 4;
  localparam int unsigned VOTE_W     = 8;
  localparam int unsigned PAIR_W     = 64;
  localparam int unsigned PAIRS      = 4;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned VAL_FULL_W = PAIRS * PAIR_W;

  // Message commands
  localparam logic [CMD_W-1:0] CMD_PREPARE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACCEPT  = 2'd1;

  typedef enum logic [1:0] {
    ACT_DROP     = 2'd0,
    ACT_PROMISE  = 2'd1,
    ACT_ACCEPTED = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC
  } back_st_e;

  // Classified request as held in the queue
  typedef struct packed {
    action_e                 kind;
    logic [INST_W-1:0]       inst;
    logic [RND_W-1:0]        rnd;
    logic [VAL_FULL_W-1:0]   value;
  } req_t;

  // Front-to-back queue head
  typedef struct packed {
    logic valid;
    req_t entry;
  } q_t;

  typedef struct packed {
    action_e               action;
    logic [INST_W-1:0]     inst;
    logic [RND_W-1:0]      rnd;
    logic [RND_W-1:0]      acc_rnd;
    logic [VOTE_W-1:0]     vote;
    logic [VAL_FULL_W-1:0] reply;
  } rsp_t;

  function automatic logic [VOTE_W-1:0] vote_bit(input logic [ID_W-1:0] id);
    logic [VOTE_W-1:0] v;
    v = '0;
    if (id >= 4'd1 && id <= 4'd8) begin
      v = VOTE_W'(1) << 3'(id - 4'd1);
    end
    return v;
  endfunction

endpackage

>>> design/pat_if.sv
interface pat_req_if import pat_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [INST_W-1:0]   instance_req;
  logic [RND_W-1:0]    round;
  logic [PAIR_W-1:0]   value_word0;
  logic [PAIR_W-1:0]   value_word1;
  logic [PAIR_W-1:0]   value_word2;
  logic [PAIR_W-1:0]   value_word3;

  modport source (
    output valid, command, instance_req, round,
           value_word0, value_word1, value_word2, value_word3,
    input  ready
  );
  modport sink (
    input  valid, command, instance_req, round,
           value_word0, value_word1, value_word2, value_word3,
    output ready
  );
endinterface

interface pat_rsp_if import pat_pkg::*; ();
  logic              valid;
  logic              ready;
  action_e           action;
  logic [INST_W-1:0] instance_out;
  logic [RND_W-1:0]  round_out;
  logic [RND_W-1:0]  accepted_round;
  logic [VOTE_W-1:0] vote;
  logic [PAIR_W-1:0] reply_word0;
  logic [PAIR_W-1:0] reply_word1;
  logic [PAIR_W-1:0] reply_word2;
  logic [PAIR_W-1:0] reply_word3;

  modport source (
    output valid, action, instance_out, round_out, accepted_round, vote,
           reply_word0, reply_word1, reply_word2, reply_word3,
    input  ready
  );
  modport sink (
    input  valid, action, instance_out, round_out, accepted_round, vote,
           reply_word0, reply_word1, reply_word2, reply_word3,
    output ready
  );
endinterface

interface pat_cfg_if import pat_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] acceptor_id;

  modport source (output valid, acceptor_id, input ready);
  modport sink   (input valid, acceptor_id, output ready);
endinterface

>>> design/pat_front.sv
module pat_front import pat_pkg::*; #(
  parameter int unsigned INSTANCES = PAT_INSTANCES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  pat_req_if.sink    req_i,
  output q_t         q_o,
  input  logic       q_pop_i
);

  localparam int unsigned QDEPTH = 2;

  req_t            slot_q [QDEPTH];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push;
  logic            in_range;
  req_t            entry;

  assign req_i.ready = en_i && (cnt_q != 2'(QDEPTH));
  assign push        = req_i.valid && req_i.ready;

  // Classify: out-of-range instances and unknown commands become drops
  always_comb begin
    in_range    = {1'b0, req_i.instance_req} < (INST_W + 1)'(INSTANCES);
    entry.inst  = req_i.instance_req;
    entry.rnd   = req_i.round;
    entry.value = {req_i.value_word3, req_i.value_word2,
                   req_i.value_word1, req_i.value_word0};
    priority if (!in_range) begin
      entry.kind = ACT_DROP;
    end else if (req_i.command == CMD_PREPARE) begin
      entry.kind = ACT_PROMISE;
    end else if (req_i.command == CMD_ACCEPT) begin
      entry.kind = ACT_ACCEPTED;
    end else begin
      entry.kind = ACT_DROP;
    end
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? ~rd_ptr_q : rd_ptr_q;
    unique case ({push, q_pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= entry;
    end
  end

  assign q_o.valid = (cnt_q != 2'd0);
  assign q_o.entry = slot_q[rd_ptr_q];

endmodule

>>> design/pat_back.sv
module pat_back import pat_pkg::*; #(
  parameter int unsigned INSTANCES   = PAT_INSTANCES,
  parameter int unsigned VALUE_WORDS = PAT_VALUE_WORDS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [ID_W-1:0] acceptor_id_i,
  input  q_t              q_i,
  output logic            q_pop_o,
  output logic            init_done_o,
  pat_rsp_if.source       rsp_o
);

  localparam int unsigned AW      = $clog2(INSTANCES);
  localparam int unsigned VALUE_W = VALUE_WORDS * WORD_W;
  localparam int unsigned ROW_W   = 2 * RND_W + VALUE_W;

  // Row layout: {voted value, voted round, highest round}
  logic [ROW_W-1:0]   mem_q [INSTANCES];
  logic [ROW_W-1:0]   rd_data_q;

  back_st_e           st_q, st_d;
  logic [AW-1:0]      clr_q, clr_d;
  req_t               cur_q;
  rsp_t               rsp_q, rsp_d;
  logic               out_valid_q, out_valid_d;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ROW_W-1:0]   mem_wdata;
  logic               mem_re;
  logic               out_free;
  logic               out_load;
  logic               clr_last;

  logic [RND_W-1:0]   hr;
  logic [RND_W-1:0]   vr;
  logic [VALUE_W-1:0] vval;
  logic               stale;
  action_e            kind;
  logic [ROW_W-1:0]   row_new;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign clr_last    = (clr_q == AW'(INSTANCES - 1));
  assign init_done_o = (st_q != ST_CLEAR);

  // Resolve the request against the row that ST_IDLE read into rd_data_q
  always_comb begin
    hr    = rd_data_q[RND_W-1:0];
    vr    = rd_data_q[2*RND_W-1:RND_W];
    vval  = rd_data_q[ROW_W-1:2*RND_W];
    stale = cur_q.rnd < hr;
    kind  = stale ? ACT_DROP : cur_q.kind;
    rsp_d   = '0;
    row_new = rd_data_q;
    if (kind != ACT_DROP) begin
      rsp_d.action = kind;
      rsp_d.inst   = cur_q.inst;
      rsp_d.rnd    = cur_q.rnd;
      rsp_d.vote   = vote_bit(acceptor_id_i);
    end
    unique case (kind)
      ACT_PROMISE: begin
        rsp_d.acc_rnd = vr;
        rsp_d.reply   = VAL_FULL_W'(vval);
        row_new       = {vval, vr, cur_q.rnd};
      end
      ACT_ACCEPTED: begin
        rsp_d.reply = cur_q.value;
        row_new     = {cur_q.value[VALUE_W-1:0], cur_q.rnd, cur_q.rnd};
      end
      ACT_DROP: begin
        row_new = rd_data_q;
      end
      default: begin
        row_new = rd_data_q;
      end
    endcase
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_CLEAR: if (clr_last) st_d = ST_IDLE;
      ST_IDLE:  if (q_i.valid) st_d = ST_CALC;
      ST_CALC:  if (out_free) st_d = ST_IDLE;
      default:  st_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_q.inst[AW-1:0];
    mem_wdata = row_new;
    mem_re    = 1'b0;
    q_pop_o   = 1'b0;
    out_load  = 1'b0;
    clr_d     = clr_q;
    unique case (st_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
      end
      ST_IDLE: begin
        q_pop_o = q_i.valid;
        mem_re  = q_i.valid;
      end
      ST_CALC: begin
        out_load = out_free;
        mem_we   = out_free && (kind != ACT_DROP);
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_i.entry;
    end
    if (out_load) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= mem_q[q_i.entry.inst[AW-1:0]];
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.action         = rsp_q.action;
  assign rsp_o.instance_out   = rsp_q.inst;
  assign rsp_o.round_out      = rsp_q.rnd;
  assign rsp_o.accepted_round = rsp_q.acc_rnd;
  assign rsp_o.vote           = rsp_q.vote;
  assign rsp_o.reply_word0    = rsp_q.reply[PAIR_W-1:0];
  assign rsp_o.reply_word1    = rsp_q.reply[2*PAIR_W-1:PAIR_W];
  assign rsp_o.reply_word2    = rsp_q.reply[3*PAIR_W-1:2*PAIR_W];
  assign rsp_o.reply_word3    = rsp_q.reply[4*PAIR_W-1:3*PAIR_W];

endmodule

>>> design/paxos_acceptor_table_top.sv
// Paxos acceptor with per-instance round and value tables held in one
// single-port-write memory of INSTANCES rows. After reset the block sweeps
// the memory once to clear it, one row a cycle, so no request is taken
// until the sweep is done; configuration writes are taken at any time.
// Requests go into a two-entry queue; the back end takes one at a time,
// reading its row in ST_IDLE, then in ST_CALC checking the round and
// writing the row back once the reply register is free. Every request gives
// exactly one reply, in order; a drop reply has all fields but action zero.
// Write acceptor_id only while no request is in flight.
module paxos_acceptor_table_top import pat_pkg::*; #(
  parameter int unsigned INSTANCES   = PAT_INSTANCES,
  parameter int unsigned VALUE_WORDS = PAT_VALUE_WORDS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pat_cfg_if.sink    cfg_i,
  pat_req_if.sink    req_i,
  pat_rsp_if.source  rsp_o
);

  logic [ID_W-1:0] acc_id_q, acc_id_d;
  logic            init_done;
  logic            q_pop;
  q_t              q_head;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    acc_id_d = acc_id_q;
    if (cfg_i.valid && cfg_i.ready) begin
      acc_id_d = cfg_i.acceptor_id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_id_q <= ID_W'(1);
    end else begin
      acc_id_q <= acc_id_d;
    end
  end

  pat_front #(
    .INSTANCES (INSTANCES)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (init_done),
    .req_i   (req_i),
    .q_o     (q_head),
    .q_pop_i (q_pop)
  );

  pat_back #(
    .INSTANCES   (INSTANCES),
    .VALUE_WORDS (VALUE_WORDS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .acceptor_id_i (acc_id_q),
    .q_i           (q_head),
    .q_pop_o       (q_pop),
    .init_done_o   (init_done),
    .rsp_o         (rsp_o)
  );

endmodule

>>> tb/tb_paxos_acceptor_table_top.sv
`timescale 1ns / 1ps

module tb_paxos_acceptor_table_top import pat_pkg::*; ();

  localparam int unsigned RANDOM_PER_PHASE = 210;
  localparam int unsigned PHASES           = 6;
  localparam int unsigned HOT_COUNT        = 8;
  localparam int unsigned SETTLE_CYCLES    = 20;
  // the limit must also cover the post-reset clear sweep of all PAT_INSTANCES rows
  localparam int unsigned WATCHDOG_LIMIT   = 3 * PAT_INSTANCES + 4096;
  localparam int unsigned REPORT_LIMIT     = 10;
  localparam int          SIDE_SEND        = 0;
  localparam int          SIDE_RECV        = 1;

  localparam logic [CMD_W-1:0] CMD_OTHER_LO = 2'd2;
  localparam logic [CMD_W-1:0] CMD_OTHER_HI = 2'd3;
  localparam logic [ID_W-1:0]  ID_AT_RESET  = 4'd1;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [INST_W-1:0]     inst;
    logic [RND_W-1:0]      rnd;
    logic [VAL_FULL_W-1:0] value;
  } paxos_msg_t;

  typedef struct packed {
    paxos_msg_t msg;
    logic       typed;
    rsp_t       want;
  } probe_row_t;

  logic clk = 1'b0;
  logic rst_n;

  pat_cfg_if cfg_bus ();
  pat_req_if req_bus ();
  pat_rsp_if rsp_bus ();

  paxos_acceptor_table_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_bus),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Acceptor tables as the block should hold them
  bit   [RND_W-1:0]      promised_round [PAT_INSTANCES];
  bit   [RND_W-1:0]      voted_round_tbl [PAT_INSTANCES];
  bit   [VAL_FULL_W-1:0] voted_value_tbl [PAT_INSTANCES];
  logic [ID_W-1:0]       acceptor_id_now = ID_AT_RESET;

  rsp_t            pending_replies [$];
  probe_row_t      probe_table [$];
  logic [INST_W-1:0] hot_pool [HOT_COUNT];
  int unsigned     calm_left [2];
  int unsigned     fault_count;
  int unsigned     idle_cycles;

  function automatic rsp_t acceptor_step(input paxos_msg_t m);
    rsp_t                  r;
    logic [VAL_FULL_W-1:0] keep;
    r    = '0;
    keep = '0;
    if (m.cmd != CMD_PREPARE && m.cmd != CMD_ACCEPT) return r;
    if (m.inst >= PAT_INSTANCES) return r;
    if (m.rnd < promised_round[m.inst]) return r;
    promised_round[m.inst] = m.rnd;
    r.inst = m.inst;
    r.rnd  = m.rnd;
    if (acceptor_id_now >= 4'd1 && acceptor_id_now <= 4'd8) begin
      r.vote = VOTE_W'(1) << (acceptor_id_now - 4'd1);
    end
    if (m.cmd == CMD_PREPARE) begin
      r.action  = ACT_PROMISE;
      r.acc_rnd = voted_round_tbl[m.inst];
      r.reply   = voted_value_tbl[m.inst];
    end else begin
      r.action = ACT_ACCEPTED;
      for (int w = 0; w < 2 * PAIRS; w++) begin
        if (w < PAT_VALUE_WORDS) keep[w*WORD_W +: WORD_W] = '1;
      end
      voted_round_tbl[m.inst] = m.rnd;
      voted_value_tbl[m.inst] = m.value & keep;
      r.reply = m.value;
    end
    return r;
  endfunction

  function automatic probe_row_t plain_row(input logic [CMD_W-1:0] cmd,
                                           input logic [INST_W-1:0] inst,
                                           input logic [RND_W-1:0] rnd,
                                           input logic [VAL_FULL_W-1:0] value);
    probe_row_t row;
    row           = '0;
    row.msg.cmd   = cmd;
    row.msg.inst  = inst;
    row.msg.rnd   = rnd;
    row.msg.value = value;
    return row;
  endfunction

  function automatic probe_row_t typed_row(input logic [CMD_W-1:0] cmd,
                                           input logic [INST_W-1:0] inst,
                                           input logic [RND_W-1:0] rnd,
                                           input logic [VAL_FULL_W-1:0] value,
                                           input action_e act,
                                           input logic [RND_W-1:0] acc_rnd,
                                           input logic [VOTE_W-1:0] vote,
                                           input logic [VAL_FULL_W-1:0] reply);
    probe_row_t row;
    row              = plain_row(cmd, inst, rnd, value);
    row.typed        = 1'b1;
    row.want.action  = act;
    if (act != ACT_DROP) begin
      row.want.inst    = inst;
      row.want.rnd     = rnd;
      row.want.acc_rnd = acc_rnd;
      row.want.vote    = vote;
      row.want.reply   = reply;
    end
    return row;
  endfunction

  // Zero-wait stretches now and then, otherwise a random wait drawn per item
  function automatic int unsigned draw_wait(input int side);
    if (calm_left[side] != 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left[side] = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  // Well-formed prepare/accept runs on a few hot instances, plus stale,
  // foreign-command and fully random messages
  function automatic paxos_msg_t draw_message();
    paxos_msg_t  m;
    int unsigned pick;
    int unsigned top;
    int unsigned bump;
    m = '0;
    if ($urandom_range(0, 99) < 70) begin
      m.inst = hot_pool[$urandom_range(0, HOT_COUNT - 1)];
    end else begin
      m.inst = INST_W'($urandom_range(0, 65535));
    end
    for (int w = 0; w < 2 * PAIRS; w++) m.value[w*WORD_W +: WORD_W] = $urandom();
    top  = promised_round[m.inst];
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      bump  = $urandom_range(0, 3);
      m.cmd = CMD_PREPARE;
      m.rnd = (top + bump > 65535) ? 16'hFFFF : RND_W'(top + bump);
    end else if (pick < 75) begin
      m.cmd = CMD_ACCEPT;
      m.rnd = RND_W'(top);
    end else if (pick < 85) begin
      m.cmd = $urandom_range(0, 1) ? CMD_ACCEPT : CMD_PREPARE;
      m.rnd = (top == 0) ? '0 : RND_W'($urandom_range(0, top - 1));
    end else if (pick < 93) begin
      m.cmd = $urandom_range(0, 1) ? CMD_OTHER_HI : CMD_OTHER_LO;
      m.rnd = RND_W'($urandom_range(0, 65535));
    end else begin
      m.cmd = CMD_W'($urandom_range(0, 3));
      m.rnd = RND_W'($urandom_range(0, 65535));
    end
    return m;
  endfunction

  task automatic push_request(input probe_row_t row);
    int unsigned gap;
    rsp_t        predicted;
    gap = draw_wait(SIDE_SEND);
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid        <= 1'b1;
    req_bus.command      <= row.msg.cmd;
    req_bus.instance_req <= row.msg.inst;
    req_bus.round        <= row.msg.rnd;
    req_bus.value_word0  <= row.msg.value[0*PAIR_W +: PAIR_W];
    req_bus.value_word1  <= row.msg.value[1*PAIR_W +: PAIR_W];
    req_bus.value_word2  <= row.msg.value[2*PAIR_W +: PAIR_W];
    req_bus.value_word3  <= row.msg.value[3*PAIR_W +: PAIR_W];
    do @(posedge clk); while (!req_bus.ready);
    // advance the tables even where the reply is typed in the table
    predicted = acceptor_step(row.msg);
    pending_replies.push_back(row.typed ? row.want : predicted);
  endtask

  task automatic drain_replies();
    req_bus.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_acceptor_id(input logic [ID_W-1:0] id);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.acceptor_id <= id;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid   <= 1'b0;
    acceptor_id_now = id;
  endtask

  // Response side: random stalls before each reply
  initial begin : reply_pacer
    int unsigned stall;
    rsp_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = draw_wait(SIDE_RECV);
      if (stall != 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!rsp_bus.valid);
    end
  end

  always @(posedge clk) begin : reply_check
    rsp_t got;
    rsp_t want;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      got.action  = rsp_bus.action;
      got.inst    = rsp_bus.instance_out;
      got.rnd     = rsp_bus.round_out;
      got.acc_rnd = rsp_bus.accepted_round;
      got.vote    = rsp_bus.vote;
      got.reply   = {rsp_bus.reply_word3, rsp_bus.reply_word2,
                     rsp_bus.reply_word1, rsp_bus.reply_word0};
      if (pending_replies.size() == 0) begin
        if (fault_count < REPORT_LIMIT) begin
          $display("%0t: reply with nothing outstanding: action %0d inst %h rnd %h",
                   $realtime, got.action, got.inst, got.rnd);
        end
        fault_count++;
      end else begin
        want = pending_replies.pop_front();
        if (got.action !== want.action || got.inst !== want.inst ||
            got.rnd !== want.rnd || got.acc_rnd !== want.acc_rnd ||
            got.vote !== want.vote || got.reply !== want.reply) begin
          if (fault_count < REPORT_LIMIT) begin
            $display("%0t: reply mismatch", $realtime);
            $display("  action   exp %0d got %0d", want.action, got.action);
            $display("  inst     exp %h got %h", want.inst, got.inst);
            $display("  round    exp %h got %h", want.rnd, got.rnd);
            $display("  acc_rnd  exp %h got %h", want.acc_rnd, got.acc_rnd);
            $display("  vote     exp %h got %h", want.vote, got.vote);
            $display("  reply    exp %h", want.reply);
            $display("           got %h", got.reply);
          end
          fault_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic [VAL_FULL_W-1:0] pat_a;
    logic [VAL_FULL_W-1:0] pat_b;
    logic [VAL_FULL_W-1:0] pat_c;
    logic [VAL_FULL_W-1:0] ones;
    logic [ID_W-1:0]       id_plan [PHASES];
    probe_row_t            rand_row;

    idle_cycles          = 0;
    fault_count          = 0;
    calm_left[SIDE_SEND] = 0;
    calm_left[SIDE_RECV] = 0;
    rst_n                <= 1'b0;
    req_bus.valid        <= 1'b0;
    req_bus.command      <= CMD_PREPARE;
    req_bus.instance_req <= '0;
    req_bus.round        <= '0;
    req_bus.value_word0  <= '0;
    req_bus.value_word1  <= '0;
    req_bus.value_word2  <= '0;
    req_bus.value_word3  <= '0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.acceptor_id  <= ID_AT_RESET;

    pat_a = {4{64'h0123_4567_89AB_CDEF}};
    pat_b = {16{16'h5555}};
    pat_c = {16{16'hAAAA}};
    ones  = '1;

    hot_pool[0] = '0;
    hot_pool[1] = '1;
    for (int i = 2; i < HOT_COUNT; i++) hot_pool[i] = INST_W'($urandom_range(0, 65535));

    id_plan[0] = 4'd8;
    id_plan[1] = 4'd0;
    id_plan[2] = 4'd15;
    id_plan[3] = ID_W'($urandom_range(2, 7));
    id_plan[4] = ID_W'($urandom_range(1, 8));
    id_plan[5] = 4'd1;

    // fresh tables, reset id, so early promises read zero and vote bit 0
    probe_table.push_back(typed_row(CMD_PREPARE, 16'h0000, 16'h0000, pat_a,
                                    ACT_PROMISE, '0, 8'h01, '0));
    probe_table.push_back(typed_row(CMD_PREPARE, 16'hFFFF, 16'hFFFF, pat_a,
                                    ACT_PROMISE, '0, 8'h01, '0));
    probe_table.push_back(typed_row(CMD_ACCEPT, 16'hFFFF, 16'hFFFF, ones,
                                    ACT_ACCEPTED, '0, 8'h01, ones));
    probe_table.push_back(plain_row(CMD_PREPARE, 16'hFFFF, 16'hFFFF, '0));
    probe_table.push_back(typed_row(CMD_PREPARE, 16'hFFFF, 16'hFFFE, pat_a,
                                    ACT_DROP, '0, '0, '0));
    probe_table.push_back(typed_row(CMD_ACCEPT, 16'hFFFF, 16'h0000, pat_a,
                                    ACT_DROP, '0, '0, '0));
    probe_table.push_back(typed_row(CMD_OTHER_LO, 16'h0005, 16'h0064, pat_a,
                                    ACT_DROP, '0, '0, '0));
    probe_table.push_back(typed_row(CMD_OTHER_HI, 16'h0005, 16'h0064, ones,
                                    ACT_DROP, '0, '0, '0));
    probe_table.push_back(typed_row(CMD_PREPARE, 16'h0005, 16'h0000, '0,
                                    ACT_PROMISE, '0, 8'h01, '0));
    probe_table.push_back(plain_row(CMD_ACCEPT, 16'h0005, 16'h0003, pat_a));
    probe_table.push_back(plain_row(CMD_ACCEPT, 16'h0005, 16'h0003, pat_b));
    probe_table.push_back(typed_row(CMD_PREPARE, 16'h0005, 16'h0002, pat_b,
                                    ACT_DROP, '0, '0, '0));
    probe_table.push_back(plain_row(CMD_PREPARE, 16'h0005, 16'h0007, '0));
    probe_table.push_back(typed_row(CMD_ACCEPT, 16'h0005, 16'h0006, pat_c,
                                    ACT_DROP, '0, '0, '0));
    probe_table.push_back(plain_row(CMD_ACCEPT, 16'h0005, 16'h0007, pat_c));
    probe_table.push_back(plain_row(CMD_PREPARE, 16'h0000, 16'h0001, pat_a));
    probe_table.push_back(plain_row(CMD_ACCEPT, 16'h0000, 16'hFFFF, pat_b));
    probe_table.push_back(plain_row(CMD_PREPARE, 16'h0000, 16'hFFFF, pat_c));
    probe_table.push_back(plain_row(CMD_ACCEPT, 16'h8000, 16'h8000, pat_c));
    probe_table.push_back(plain_row(CMD_PREPARE, 16'h7FFF, 16'h7FFF, pat_a));
    probe_table.push_back(plain_row(CMD_PREPARE, 16'h8000, 16'h8000, '0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (probe_table[i]) push_request(probe_table[i]);

    for (int ph = 0; ph < PHASES; ph++) begin
      // hold requests until every reply is back before touching the id
      drain_replies();
      write_acceptor_id(id_plan[ph]);
      repeat (RANDOM_PER_PHASE) begin
        rand_row     = '0;
        rand_row.msg = draw_message();
        push_request(rand_row);
      end
    end

    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    fault_count += pending_replies.size();

    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
design/pat_pkg.sv
design/pat_if.sv
design/pat_front.sv
design/pat_back.sv
design/paxos_acceptor_table_top.sv
tb/tb_paxos_acceptor_table_top.sv
